>>> src/dtc_pkg.sv
// Package for the epoch-milliseconds to calendar fields unit.
// Holds field widths, pipeline depths, stage payload types and the reciprocal constants
// used for the constant divisions. No dependencies.
package dtc_pkg;

    // Field widths
    localparam int TIME_W  = 48;
    localparam int DAY_W   = 22;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;

    // Day divider: 86400000 = 84375 * 2^10, restoring division of time_ms >> 10 by 84375
    localparam int MS_SHIFT   = 10;
    localparam int DIVIDEND_W = TIME_W - MS_SHIFT;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 6;
    localparam int QUO_W      = DIV_STEPS * DIV_STAGES;
    localparam int REM_W      = 17;
    localparam int REM_INIT_W = DIVIDEND_W - QUO_W;
    localparam logic [REM_W-1:0] DAY_DIV = 17'd84375;
    localparam int TOD_W      = REM_W + MS_SHIFT;

    // Pipeline layout
    localparam int DATE_STAGES  = 7;
    localparam int CLOCK_STAGES = 3;
    localparam int TOTAL_STAGES = DIV_STAGES + DATE_STAGES;
    localparam int CLOCK_START  = TOTAL_STAGES - CLOCK_STAGES;
    localparam int TOD_DELAY    = CLOCK_START - DIV_STAGES;

    // Time of day split
    localparam int SOD_SHIFT     = 3;
    localparam int SOD_IN_W      = TOD_W - SOD_SHIFT;
    localparam int SOD_W         = 17;
    localparam int SOD_K         = 31;
    localparam int SOD_RECIP_W   = 25;
    localparam int SOD_PROD_W    = SOD_IN_W + SOD_RECIP_W;
    localparam logic [SOD_RECIP_W-1:0] SOD_RECIP =
        SOD_RECIP_W'(((64'd1 << SOD_K) + 64'd124) / 64'd125);
    localparam int HOUR_K        = 29;
    localparam int HOUR_RECIP_W  = 18;
    localparam int HOUR_PROD_W   = SOD_W + HOUR_RECIP_W;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
        HOUR_RECIP_W'(((64'd1 << HOUR_K) + 64'd3599) / 64'd3600);
    localparam int MOD_W         = 11;
    localparam int MOD_K         = 23;
    localparam int MOD_RECIP_W   = 18;
    localparam int MOD_PROD_W    = SOD_W + MOD_RECIP_W;
    localparam logic [MOD_RECIP_W-1:0] MOD_RECIP =
        MOD_RECIP_W'(((64'd1 << MOD_K) + 64'd59) / 64'd60);
    localparam logic [TOD_W-1:0] MS_PER_SEC  = TOD_W'(1000);
    localparam logic [SOD_W-1:0] SEC_PER_MIN = SOD_W'(60);
    localparam logic [MOD_W-1:0] MIN_PER_HR  = MOD_W'(60);

    // Civil date from day count, eras of 400 years starting 0000-03-01
    localparam int Z_W          = 23;
    localparam logic [Z_W-1:0] EPOCH_SHIFT = 23'd719468;
    localparam int ERA_W        = 6;
    localparam int ERA_K        = 41;
    localparam int ERA_RECIP_W  = 24;
    localparam int ERA_PROD_W   = Z_W + ERA_RECIP_W;
    localparam logic [ERA_RECIP_W-1:0] ERA_RECIP =
        ERA_RECIP_W'(((64'd1 << ERA_K) + 64'd146096) / 64'd146097);
    localparam logic [Z_W-1:0] ERA_DAYS = Z_W'(146097);
    localparam int DOE_W        = 18;
    localparam logic [DOE_W-1:0] ERA_LAST = DOE_W'(146096);
    localparam logic [DOE_W-1:0] CENT_DAYS = DOE_W'(36524);
    localparam int A_W          = 7;
    localparam int A_K          = 29;
    localparam int A_RECIP_W    = 19;
    localparam int A_PROD_W     = DOE_W + A_RECIP_W;
    localparam logic [A_RECIP_W-1:0] A_RECIP =
        A_RECIP_W'(((64'd1 << A_K) + 64'd1459) / 64'd1460);
    localparam int YOE_W        = 9;
    localparam int YEAR_K       = 27;
    localparam int YEAR_RECIP_W = 19;
    localparam int YEAR_PROD_W  = DOE_W + YEAR_RECIP_W;
    localparam logic [YEAR_RECIP_W-1:0] YEAR_RECIP =
        YEAR_RECIP_W'(((64'd1 << YEAR_K) + 64'd364) / 64'd365);
    localparam logic [DOE_W-1:0] YEAR_DAYS = DOE_W'(365);
    localparam int CENT_W       = 3;
    localparam int CENT_K       = 16;
    localparam int CENT_RECIP_W = 10;
    localparam int CENT_PROD_W  = YOE_W + CENT_RECIP_W;
    localparam logic [CENT_RECIP_W-1:0] CENT_RECIP =
        CENT_RECIP_W'(((64'd1 << CENT_K) + 64'd99) / 64'd100);
    localparam int MP_W         = 4;
    localparam int V_W          = 11;
    localparam int MP_K         = 19;
    localparam int MP_RECIP_W   = 12;
    localparam int MP_PROD_W    = V_W + MP_RECIP_W;
    localparam logic [MP_RECIP_W-1:0] MP_RECIP =
        MP_RECIP_W'(((64'd1 << MP_K) + 64'd152) / 64'd153);
    localparam logic [MP_W-1:0] MP_JAN = 4'd10;
    localparam logic [DOY_W-1:0] JAN_OFFSET = 9'd306;
    localparam logic [DOY_W-1:0] MAR_DOY    = 9'd59;
    localparam int Y_SUM_W = YEAR_W + 1;
    localparam logic [Y_SUM_W-1:0] ERA_YEARS = Y_SUM_W'(400);
    localparam logic [YOE_W-1:0] CENT_1 = 9'd100;
    localparam logic [YOE_W-1:0] CENT_2 = 9'd200;
    localparam logic [YOE_W-1:0] CENT_3 = 9'd300;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [QUO_W-1:0]    num;
        logic [QUO_W-1:0]    quo;
        logic [MS_SHIFT-1:0] low;
    } div_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day_number;
        logic [YEAR_W-1:0]  year;
        logic               leap_year;
        logic [DOY_W-1:0]   day_of_year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
    } date_fields_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [MSEC_W-1:0] millisecond;
    } clock_fields_t;

endpackage

>>> src/dtc_if.sv
// Valid/ready channel interfaces for the calendar fields unit.
// Depends on dtc_pkg for field widths.
interface dtc_stamp_if;
    import dtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_ms;
    modport source (output valid, output time_ms, input ready);
    modport sink (input valid, input time_ms, output ready);
endinterface

interface dtc_fields_if;
    import dtc_pkg::*;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   day_number;
    logic [YEAR_W-1:0]  year;
    logic               leap_year;
    logic [DOY_W-1:0]   day_of_year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MSEC_W-1:0]  millisecond;
    modport source (output valid, output day_number, output year, output leap_year,
                    output day_of_year, output month, output day_of_month, output hour,
                    output minute, output second, output millisecond, input ready);
    modport sink (input valid, input day_number, input year, input leap_year,
                  input day_of_year, input month, input day_of_month, input hour,
                  input minute, input second, input millisecond, output ready);
endinterface

>>> src/dtc_div_stage.sv
// One stage of the day divider: four restoring division steps by 84375.
// Depends on dtc_pkg.
module dtc_div_stage (
    input  logic          clk,
    input  logic          en,
    input  dtc_pkg::div_t d,
    output dtc_pkg::div_t q
);
    import dtc_pkg::*;

    div_t           q_reg;
    div_t           q_next;
    logic [REM_W:0] trial;

    always_comb
    begin
        q_next = d;
        trial  = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {q_next.rem, q_next.num[QUO_W-1]};
            q_next.num = {q_next.num[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, DAY_DIV})
            begin
                q_next.rem = REM_W'(trial - {1'b0, DAY_DIV});
                q_next.quo = {q_next.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_next.rem = trial[REM_W-1:0];
                q_next.quo = {q_next.quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> src/dtc_clock_split.sv
// Three-stage split of the millisecond of day into hour, minute, second, millisecond.
// Depends on dtc_pkg; divisions use exact reciprocal multiplies.
module dtc_clock_split (
    input  logic                                clk,
    input  logic [dtc_pkg::CLOCK_STAGES-1:0]    en,
    input  logic [dtc_pkg::TOD_W-1:0]           tod,
    output dtc_pkg::clock_fields_t              result
);
    import dtc_pkg::*;

    logic [SOD_PROD_W-1:0]  sod_prod;
    logic [SOD_W-1:0]       sod1_next;
    logic [SOD_W-1:0]       sod1_reg;
    logic [TOD_W-1:0]       tod1_reg;

    logic [HOUR_PROD_W-1:0] hour_prod;
    logic [MOD_PROD_W-1:0]  mod_prod;
    logic [MSEC_W-1:0]      ms2_next;
    logic [HOUR_W-1:0]      hour2_next;
    logic [MOD_W-1:0]       mod2_next;
    logic [MSEC_W-1:0]      ms2_reg;
    logic [HOUR_W-1:0]      hour2_reg;
    logic [MOD_W-1:0]       mod2_reg;
    logic [SOD_W-1:0]       sod2_reg;

    clock_fields_t          result_next;
    clock_fields_t          result_reg;

    always_comb
    begin
        sod_prod  = SOD_PROD_W'(tod[TOD_W-1:SOD_SHIFT]) * SOD_PROD_W'(SOD_RECIP);
        sod1_next = sod_prod[SOD_K +: SOD_W];
    end

    always_comb
    begin
        ms2_next   = MSEC_W'(tod1_reg - TOD_W'(sod1_reg) * MS_PER_SEC);
        hour_prod  = HOUR_PROD_W'(sod1_reg) * HOUR_PROD_W'(HOUR_RECIP);
        hour2_next = hour_prod[HOUR_K +: HOUR_W];
        mod_prod   = MOD_PROD_W'(sod1_reg) * MOD_PROD_W'(MOD_RECIP);
        mod2_next  = mod_prod[MOD_K +: MOD_W];
    end

    always_comb
    begin
        result_next.millisecond = ms2_reg;
        result_next.hour        = hour2_reg;
        result_next.second      = SEC_W'(sod2_reg - SOD_W'(mod2_reg) * SEC_PER_MIN);
        result_next.minute      = MIN_W'(mod2_reg - MOD_W'(hour2_reg) * MIN_PER_HR);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sod1_reg <= sod1_next;
            tod1_reg <= tod;
        end
        if (en[1])
        begin
            ms2_reg   <= ms2_next;
            hour2_reg <= hour2_next;
            mod2_reg  <= mod2_next;
            sod2_reg  <= sod1_reg;
        end
        if (en[2])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> src/dtc_date_calc.sv
// Seven-stage civil date pipeline: day count to year, leap flag, day of year, month, date.
// Depends on dtc_pkg; works in 400-year eras counted from 0000-03-01.
module dtc_date_calc (
    input  logic                             clk,
    input  logic [dtc_pkg::DATE_STAGES-1:0]  en,
    input  logic [dtc_pkg::DAY_W-1:0]        days,
    output dtc_pkg::date_fields_t            result
);
    import dtc_pkg::*;

    function automatic logic [DOY_W-1:0] month_base(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] base;
        unique case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

    logic [DAY_W-1:0]       day_reg [DATE_STAGES-1];

    logic [Z_W-1:0]         z1_next;
    logic [ERA_PROD_W-1:0]  era_prod;
    logic [ERA_W-1:0]       era1_next;
    logic [Z_W-1:0]         z1_reg;
    logic [ERA_W-1:0]       era1_reg;

    logic [Z_W-1:0]         era_days;
    logic [DOE_W-1:0]       doe2_next;
    logic [DOE_W-1:0]       doe2_reg;
    logic [ERA_W-1:0]       era2_reg;

    logic [A_PROD_W-1:0]    a_prod;
    logic [A_W-1:0]         a_val;
    logic [2:0]             b_val;
    logic                   c_val;
    logic [DOE_W-1:0]       n3_next;
    logic [DOE_W-1:0]       n3_reg;
    logic [DOE_W-1:0]       doe3_reg;
    logic [ERA_W-1:0]       era3_reg;

    logic [YEAR_PROD_W-1:0] yoe_prod;
    logic [YOE_W-1:0]       yoe4_next;
    logic [YOE_W-1:0]       yoe4_reg;
    logic [DOE_W-1:0]       doe4_reg;
    logic [ERA_W-1:0]       era4_reg;

    logic [CENT_PROD_W-1:0] cent_prod;
    logic [CENT_W-1:0]      cent_val;
    logic [DOE_W-1:0]       year_base;
    logic [DOY_W-1:0]       doym5_next;
    logic [DOY_W-1:0]       doym5_reg;
    logic [YOE_W-1:0]       yoe5_reg;
    logic [ERA_W-1:0]       era5_reg;

    logic [V_W-1:0]         v_val;
    logic [MP_PROD_W-1:0]   mp_prod;
    logic [MP_W-1:0]        mp6_next;
    logic [MP_W-1:0]        mp6_reg;
    logic [DOY_W-1:0]       doym6_reg;
    logic [YOE_W-1:0]       yoe6_reg;
    logic [ERA_W-1:0]       era6_reg;

    logic                   jan_feb;
    logic [YOE_W-1:0]       y400;
    logic                   leap;
    logic [Y_SUM_W-1:0]     year_sum;
    date_fields_t           result_next;
    date_fields_t           result_reg;

    always_comb
    begin
        z1_next   = Z_W'(days) + EPOCH_SHIFT;
        era_prod  = ERA_PROD_W'(z1_next) * ERA_PROD_W'(ERA_RECIP);
        era1_next = era_prod[ERA_K +: ERA_W];
    end

    always_comb
    begin
        era_days  = Z_W'(era1_reg) * ERA_DAYS;
        doe2_next = DOE_W'(z1_reg - era_days);
    end

    always_comb
    begin
        a_prod  = A_PROD_W'(doe2_reg) * A_PROD_W'(A_RECIP);
        a_val   = a_prod[A_K +: A_W];
        b_val   = 3'(doe2_reg >= CENT_DAYS) + 3'(doe2_reg >= DOE_W'(2 * 36524))
                + 3'(doe2_reg >= DOE_W'(3 * 36524)) + 3'(doe2_reg >= ERA_LAST);
        c_val   = (doe2_reg == ERA_LAST);
        n3_next = doe2_reg - DOE_W'(a_val) + DOE_W'(b_val) - DOE_W'(c_val);
    end

    always_comb
    begin
        yoe_prod  = YEAR_PROD_W'(n3_reg) * YEAR_PROD_W'(YEAR_RECIP);
        yoe4_next = yoe_prod[YEAR_K +: YOE_W];
    end

    always_comb
    begin
        cent_prod  = CENT_PROD_W'(yoe4_reg) * CENT_PROD_W'(CENT_RECIP);
        cent_val   = cent_prod[CENT_K +: CENT_W];
        year_base  = DOE_W'(yoe4_reg) * YEAR_DAYS + DOE_W'(yoe4_reg >> 2) - DOE_W'(cent_val);
        doym5_next = DOY_W'(doe4_reg - year_base);
    end

    always_comb
    begin
        v_val    = V_W'({doym5_reg, 2'b00}) + V_W'(doym5_reg) + V_W'(2);
        mp_prod  = MP_PROD_W'(v_val) * MP_PROD_W'(MP_RECIP);
        mp6_next = mp_prod[MP_K +: MP_W];
    end

    always_comb
    begin
        jan_feb  = (mp6_reg >= MP_JAN);
        y400     = yoe6_reg + YOE_W'(jan_feb);
        leap     = (y400[1:0] == 2'b00) && !(y400 == CENT_1 || y400 == CENT_2 || y400 == CENT_3);
        year_sum = Y_SUM_W'(era6_reg) * ERA_YEARS + Y_SUM_W'(y400);
        result_next.day_number   = day_reg[DATE_STAGES-2];
        result_next.year         = year_sum[YEAR_W-1:0];
        result_next.leap_year    = leap;
        result_next.month        = jan_feb ? MONTH_W'(mp6_reg - MP_JAN) : MONTH_W'(mp6_reg + 4'd2);
        result_next.day_of_month = DOM_W'(doym6_reg - month_base(mp6_reg) + 9'd1);
        if (jan_feb)
        begin
            result_next.day_of_year = doym6_reg - JAN_OFFSET;
        end
        else
        begin
            result_next.day_of_year = doym6_reg + MAR_DOY + DOY_W'(leap);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z1_reg     <= z1_next;
            era1_reg   <= era1_next;
            day_reg[0] <= days;
        end
        if (en[1])
        begin
            doe2_reg   <= doe2_next;
            era2_reg   <= era1_reg;
            day_reg[1] <= day_reg[0];
        end
        if (en[2])
        begin
            n3_reg     <= n3_next;
            doe3_reg   <= doe2_reg;
            era3_reg   <= era2_reg;
            day_reg[2] <= day_reg[1];
        end
        if (en[3])
        begin
            yoe4_reg   <= yoe4_next;
            doe4_reg   <= doe3_reg;
            era4_reg   <= era3_reg;
            day_reg[3] <= day_reg[2];
        end
        if (en[4])
        begin
            doym5_reg  <= doym5_next;
            yoe5_reg   <= yoe4_reg;
            era5_reg   <= era4_reg;
            day_reg[4] <= day_reg[3];
        end
        if (en[5])
        begin
            mp6_reg    <= mp6_next;
            doym6_reg  <= doym5_reg;
            yoe6_reg   <= yoe5_reg;
            era6_reg   <= era5_reg;
            day_reg[5] <= day_reg[4];
        end
        if (en[6])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> src/epoch_ms_to_calendar_fields_unit.sv
// Top level of the epoch-milliseconds to UTC calendar fields unit.
// Depends on dtc_pkg, dtc_if, dtc_div_stage, dtc_date_calc and dtc_clock_split.
//
// Usage:
//   stamp  : input channel, one transaction carries time_ms, milliseconds since
//            1970-01-01T00:00:00Z. A transaction completes when valid and ready are high.
//   fields : output channel, one transaction per input transaction, in order, with
//            day_number, year, leap_year, day_of_year, month, day_of_month, hour,
//            minute, second and millisecond.
//   Fields pass through 13 register stages:
//   six stages of day division (four quotient bits each) feed seven stages of date
//   arithmetic, and the time-of-day split runs in the last three of them.
//   Throughput is one transaction per cycle while fields.ready is not held low.
//   Reset clears every stage valid bit; the unit comes out of reset empty and ready.
//   When fields.ready is low the last stage holds its result. Each stage advances
//   when it is empty or the stage after it advances, so bubbles close up and
//   stamp.ready drops only once all 13 stages are full.
module epoch_ms_to_calendar_fields_unit (
    input  logic          clk,
    input  logic          rst_n,
    dtc_stamp_if.sink     stamp,
    dtc_fields_if.source  fields
);
    import dtc_pkg::*;

    logic [TOTAL_STAGES-1:0] en;
    logic [TOTAL_STAGES-1:0] valid_reg;
    logic [TOTAL_STAGES-1:0] valid_next;
    logic [TOTAL_STAGES-1:0] valid_src;

    div_t                    div_pipe [DIV_STAGES+1];
    logic [TOD_W-1:0]        tod_src;
    logic [TOD_W-1:0]        tod_reg [TOD_DELAY];
    date_fields_t            date_out;
    clock_fields_t           clock_out;

    always_comb
    begin
        en[TOTAL_STAGES-1] = ~valid_reg[TOTAL_STAGES-1] | fields.ready;
        for (int i = TOTAL_STAGES - 2; i >= 0; i--)
        begin
            en[i] = ~valid_reg[i] | en[i+1];
        end
    end

    always_comb
    begin
        valid_src = {valid_reg[TOTAL_STAGES-2:0], stamp.valid};
        for (int i = 0; i < TOTAL_STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_src[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        div_pipe[0].rem = REM_W'(stamp.time_ms[TIME_W-1 -: REM_INIT_W]);
        div_pipe[0].num = stamp.time_ms[MS_SHIFT +: QUO_W];
        div_pipe[0].quo = '0;
        div_pipe[0].low = stamp.time_ms[MS_SHIFT-1:0];
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        dtc_div_stage u_div_stage (
            .clk (clk),
            .en  (en[g]),
            .d   (div_pipe[g]),
            .q   (div_pipe[g+1])
        );
    end

    assign tod_src = {div_pipe[DIV_STAGES].rem, div_pipe[DIV_STAGES].low};

    always_ff @(posedge clk)
    begin
        if (en[DIV_STAGES])
        begin
            tod_reg[0] <= tod_src;
        end
        for (int k = 1; k < TOD_DELAY; k++)
        begin
            if (en[DIV_STAGES+k])
            begin
                tod_reg[k] <= tod_reg[k-1];
            end
        end
    end

    dtc_date_calc u_date_calc (
        .clk    (clk),
        .en     (en[DIV_STAGES +: DATE_STAGES]),
        .days   (div_pipe[DIV_STAGES].quo[DAY_W-1:0]),
        .result (date_out)
    );

    dtc_clock_split u_clock_split (
        .clk    (clk),
        .en     (en[CLOCK_START +: CLOCK_STAGES]),
        .tod    (tod_reg[TOD_DELAY-1]),
        .result (clock_out)
    );

    assign stamp.ready         = en[0];
    assign fields.valid        = valid_reg[TOTAL_STAGES-1];
    assign fields.day_number   = date_out.day_number;
    assign fields.year         = date_out.year;
    assign fields.leap_year    = date_out.leap_year;
    assign fields.day_of_year  = date_out.day_of_year;
    assign fields.month        = date_out.month;
    assign fields.day_of_month = date_out.day_of_month;
    assign fields.hour         = clock_out.hour;
    assign fields.minute       = clock_out.minute;
    assign fields.second       = clock_out.second;
    assign fields.millisecond  = clock_out.millisecond;

endmodule

>>> verif/tb_epoch_ms_to_calendar_fields_unit.sv
// Self-checking testbench for epoch_ms_to_calendar_fields_unit.
// Drives millisecond timestamps through dtc_stamp_if and checks each dtc_fields_if
// transaction against an in-bench calendar predictor; depends on dtc_pkg and dtc_if.
module tb_epoch_ms_to_calendar_fields_unit;
    import dtc_pkg::*;

    localparam longint unsigned DAY_MSEC      = 64'd86400000;
    localparam longint unsigned HOUR_MSEC     = 64'd3600000;
    localparam longint unsigned MINUTE_MSEC   = 64'd60000;
    localparam longint unsigned SECOND_MSEC   = 64'd1000;
    localparam longint unsigned LAST_IN_RANGE = 64'd253402300799999;
    localparam int unsigned     FIRST_YEAR    = 1970;
    localparam int              STALL_LIMIT   = 5000;
    localparam int              HOLD_CYCLES   = 80;
    localparam int              DRAIN_CYCLES  = 30;

    typedef struct packed {
        logic [DAY_W-1:0]   day_number;
        logic [YEAR_W-1:0]  year;
        logic               leap_year;
        logic [DOY_W-1:0]   day_of_year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [MSEC_W-1:0]  millisecond;
    } calendar_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dtc_stamp_if  stamp ();
    dtc_fields_if fields ();

    epoch_ms_to_calendar_fields_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamp  (stamp),
        .fields (fields)
    );

    logic [TIME_W-1:0] pending_stamps [$];
    calendar_t         expected_fields [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    bit hold_active    = 1'b0;
    int queued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        if (y % 4 != 0)
            return 1'b0;
        if (y % 100 != 0)
            return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic longint unsigned year_first_day(input int unsigned y);
        return 365 * (y - 1970) + (y - 1969) / 4 - (y - 1901) / 100 + (y - 1601) / 400;
    endfunction

    function automatic int unsigned month_first_day(input int unsigned m, input bit leap);
        int unsigned base;
        case (m)
            0:       base = 0;
            1:       base = 31;
            2:       base = 59;
            3:       base = 90;
            4:       base = 120;
            5:       base = 151;
            6:       base = 181;
            7:       base = 212;
            8:       base = 243;
            9:       base = 273;
            10:      base = 304;
            default: base = 334;
        endcase
        return base + ((m >= 2 && leap) ? 1 : 0);
    endfunction

    function automatic calendar_t predict_calendar(input logic [TIME_W-1:0] t);
        calendar_t        c;
        longint unsigned  days;
        longint unsigned  tod;
        int unsigned      y;
        int unsigned      doy;
        int unsigned      m;
        bit               leap;
        days = 64'(t) / DAY_MSEC;
        tod  = 64'(t) % DAY_MSEC;
        y    = FIRST_YEAR + int'(days / 365);
        while (y > FIRST_YEAR && year_first_day(y) > days)
            y--;
        while (year_first_day(y + 1) <= days)
            y++;
        leap = is_leap_year(y);
        doy  = int'(days - year_first_day(y));
        m    = 0;
        for (int k = 1; k < 12; k++)
            if (doy >= month_first_day(k, leap))
                m = k;
        c.day_number   = DAY_W'(days);
        c.year         = YEAR_W'(y);
        c.leap_year    = leap;
        c.day_of_year  = DOY_W'(doy);
        c.month        = MONTH_W'(m);
        c.day_of_month = DOM_W'(doy - month_first_day(m, leap) + 1);
        c.hour         = HOUR_W'(tod / HOUR_MSEC);
        c.minute       = MIN_W'((tod / MINUTE_MSEC) % 60);
        c.second       = SEC_W'((tod / SECOND_MSEC) % 60);
        c.millisecond  = MSEC_W'(tod % SECOND_MSEC);
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] random_stamp();
        logic [63:0]     raw;
        longint unsigned base;
        longint unsigned offset;
        int unsigned     y;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(3))
            0, 1:
                return raw[TIME_W-1:0];
            2:
                return TIME_W'(64'(raw[TIME_W-1:0]) % (LAST_IN_RANGE + 1));
            default:
            begin
                y      = $urandom_range(10888, 1971);
                base   = (year_first_day(y) + month_first_day($urandom_range(11),
                          is_leap_year(y))) * DAY_MSEC;
                offset = 64'(raw[31:0]) % (3 * DAY_MSEC);
                if ($urandom_range(1))
                    return TIME_W'(base + offset);
                return TIME_W'(base - 1 - offset);
            end
        endcase
    endfunction

    task automatic check_field(input string label, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    task automatic queue_stamp(input logic [TIME_W-1:0] t);
        pending_stamps.push_back(t);
        queued_count++;
    endtask

    task automatic wait_accepted();
        while (accepted_count != queued_count)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        wait_accepted();
        while (expected_fields.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            queue_stamp(random_stamp());
        wait_accepted();
    endtask

    // Driver: advance the stamp channel when the current transaction is taken or none is held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp.valid   <= 1'b0;
            stamp.time_ms <= '0;
        end
        else
        begin
            if (stamp.valid && stamp.ready)
            begin
                expected_fields.push_back(predict_calendar(stamp.time_ms));
                accepted_count++;
            end
            if (!stamp.valid || stamp.ready)
            begin
                if (pending_stamps.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    stamp.valid   <= 1'b1;
                    stamp.time_ms <= pending_stamps.pop_front();
                end
                else
                    stamp.valid <= 1'b0;
            end
        end
    end

    // Receiver hold: count the long stall in cycles once requested.
    always
    begin
        wait (hold_request);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active  = 1'b0;
        hold_request = 1'b0;
    end

    // Monitor: compare each fields transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        calendar_t want;
        if (!rst_n)
            fields.ready <= 1'b0;
        else
        begin
            if (fields.valid && fields.ready)
            begin
                if (expected_fields.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual day_number %0d",
                             $time, fields.day_number);
                end
                else
                begin
                    want = expected_fields.pop_front();
                    check_field("day_number", want.day_number, fields.day_number);
                    check_field("year", want.year, fields.year);
                    check_field("leap_year", want.leap_year, fields.leap_year);
                    check_field("day_of_year", want.day_of_year, fields.day_of_year);
                    check_field("month", want.month, fields.month);
                    check_field("day_of_month", want.day_of_month, fields.day_of_month);
                    check_field("hour", want.hour, fields.hour);
                    check_field("minute", want.minute, fields.minute);
                    check_field("second", want.second, fields.second);
                    check_field("millisecond", want.millisecond, fields.millisecond);
                end
                checked_count++;
            end
            if (hold_active)
                fields.ready <= 1'b0;
            else
                fields.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((stamp.valid && stamp.ready) || (fields.valid && fields.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned     edge_years [8];
        longint unsigned day_ms;
        edge_years = '{1971, 1972, 2000, 2001, 2100, 2101, 2400, 10000};
        stamp.valid   = 1'b0;
        stamp.time_ms = '0;
        fields.ready  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_stamp('0);
        queue_stamp('1);
        queue_stamp(TIME_W'(DAY_MSEC - 1));
        queue_stamp(TIME_W'(DAY_MSEC));
        foreach (edge_years[i])
        begin
            day_ms = year_first_day(edge_years[i]) * DAY_MSEC;
            queue_stamp(TIME_W'(day_ms - 1));
            queue_stamp(TIME_W'(day_ms));
        end
        // Leap day in a 400-year leap year, and the skipped one in a plain century.
        day_ms = (year_first_day(2000) + 60) * DAY_MSEC;
        queue_stamp(TIME_W'(day_ms - 1));
        queue_stamp(TIME_W'(day_ms));
        day_ms = (year_first_day(2100) + 59) * DAY_MSEC;
        queue_stamp(TIME_W'(day_ms - 1));
        queue_stamp(TIME_W'(day_ms));
        wait_drained();

        run_phase(0, 0, 400);
        run_phase(71, 0, 400);
        run_phase(0, 71, 400);
        run_phase(22, 22, 400);

        // Hold the receiver off while the sender keeps offering to fill the pipeline.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 200; i++)
            queue_stamp(random_stamp());
        while (accepted_count < queued_count - 180)
            @(negedge clk);
        hold_request = 1'b1;
        wait_accepted();
        wait_drained();
        run_phase(0, 0, 100);

        recv_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d calendar conversions: year, month and day edges, full 48-bit span,",
                 checked_count);
        $display("under free-running, sender-idle, receiver-stall and backpressure phases.");
        if (error_count == 0 && expected_fields.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0t: %0d errors, %0d results outstanding", $time, error_count,
                     expected_fields.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
